@@ hdl/fmpf_pkg.sv @@
// Shared types, constants and codes of the first-match packet filter.
`default_nettype none

package fmpf_pkg;

	// Default number of rule slots.
	localparam int RULE_SLOTS_DEFAULT = 8;

	// A write item addresses at most this many entries, because its index field is three bits.
	localparam int INDEX_REACH = 8;

	// Largest rule count that the four-bit register can hold.
	localparam int COUNT_MAX = 15;
	localparam int COUNT_W   = 4;

	localparam logic [3:0] IPV4_VERSION = 4'd4;
	localparam logic [7:0] TCP_PROTOCOL = 8'd6;
	localparam logic [6:0] PORT_BYTES   = 7'd4;

	// Request operation codes.
	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_WRITE    = 1'b1;

	// Verdict outcome codes.
	localparam logic [1:0] OUTCOME_NOT_IPV4  = 2'd0;
	localparam logic [1:0] OUTCOME_TRUNCATED = 2'd1;
	localparam logic [1:0] OUTCOME_MATCHED   = 2'd2;
	localparam logic [1:0] OUTCOME_NO_MATCH  = 2'd3;

	typedef struct packed {
		logic        operation;
		logic [2:0]  rule_index;
		logic [3:0]  version;
		logic [3:0]  header_words;
		logic [15:0] first_len;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port_field;
		logic [15:0] dst_port_field;
		logic        deny_flag;
	} item_t;

	typedef struct packed {
		logic       deny;
		logic [1:0] outcome;
		logic [2:0] rule_number;
	} result_t;

	typedef struct packed {
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic        deny;
	} rule_t;

	// Which verdict the datapath records.
	typedef enum logic {
		RES_HEADER = 1'b0,
		RES_SCAN   = 1'b1
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     table_wr;
		logic     step_ptr;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic item_write;
		logic header_ok;
		logic scan_empty;
		logic hit;
		logic last;
		logic out_free;
	} ctrl_status_t;

endpackage

`default_nettype wire

@@ hdl/fmpf_ctrl.sv @@
// Sequencer of the packet filter: accept, header check, rule scan, result hand-off.
`default_nettype none

module fmpf_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire fmpf_pkg::ctrl_status_t st,
	output fmpf_pkg::ctrl_cmd_t        cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		cmd         = '0;
		cmd.res_sel = fmpf_pkg::RES_HEADER;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					if (st.item_write) begin
						cmd.table_wr = 1'b1;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (!st.header_ok || st.scan_empty) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = fmpf_pkg::RES_HEADER;
					state_d      = ST_EMIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.hit || st.last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = fmpf_pkg::RES_SCAN;
					state_d      = ST_EMIT;
				end else begin
					cmd.step_ptr = 1'b1;
				end
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/fmpf_dpath.sv @@
// Rule table, header checks, rule comparator, scan pointer and result registers.
`default_nettype none

module fmpf_dpath #(
	parameter int RULE_SLOTS = fmpf_pkg::RULE_SLOTS_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [fmpf_pkg::COUNT_W-1:0]        cfg_wr_data,
	input  wire fmpf_pkg::item_t                     item,
	input  wire logic                                result_ready,
	output logic                                     result_valid,
	output fmpf_pkg::result_t                        result,
	input  wire fmpf_pkg::ctrl_cmd_t                 cmd,
	output fmpf_pkg::ctrl_status_t                   st
);

	// Only the entries a write can reach are stored; the rest stay all-wildcard allow rules.
	localparam int STORED   = (RULE_SLOTS < fmpf_pkg::INDEX_REACH) ?
		RULE_SLOTS : fmpf_pkg::INDEX_REACH;
	localparam int MAX_SCAN = (RULE_SLOTS < fmpf_pkg::COUNT_MAX) ?
		RULE_SLOTS : fmpf_pkg::COUNT_MAX;
	localparam int SCAN_W   = $clog2(MAX_SCAN + 1);
	localparam int IDX_W    = (STORED > 1) ? $clog2(STORED) : 1;

	fmpf_pkg::rule_t                table_q [STORED];
	fmpf_pkg::item_t                hdr_q;
	logic [fmpf_pkg::COUNT_W-1:0]   rule_count_q;
	logic [SCAN_W-1:0]              ptr_q;
	logic [SCAN_W-1:0]              ptr_inc;
	logic [SCAN_W-1:0]              limit;
	fmpf_pkg::result_t              res_q;
	fmpf_pkg::result_t              out_q;
	logic                           out_valid_q;

	fmpf_pkg::rule_t                cur;
	fmpf_pkg::result_t              header_res;
	fmpf_pkg::result_t              scan_res;
	logic                           ver_bad;
	logic                           trunc;
	logic [6:0]                     need;
	logic [15:0]                    sport_eff;
	logic [15:0]                    dport_eff;
	logic                           hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORED; i++) begin
				table_q[i] <= '0;
			end
		end else if (cmd.table_wr && (32'(item.rule_index) < STORED)) begin
			table_q[item.rule_index[IDX_W-1:0]] <= '{
				proto: item.protocol,
				src:   item.src_addr,
				dst:   item.dst_addr,
				sport: item.src_port_field,
				dport: item.dst_port_field,
				deny:  item.deny_flag
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= '0;
		end else if (cfg_wr_en) begin
			rule_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hdr_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.capture) begin
			ptr_q <= '0;
		end else if (cmd.step_ptr) begin
			ptr_q <= ptr_inc;
		end
	end

	assign ptr_inc = ptr_q + SCAN_W'(1);

	always_comb begin
		if (32'(rule_count_q) > MAX_SCAN) begin
			limit = SCAN_W'(MAX_SCAN);
		end else begin
			limit = SCAN_W'(rule_count_q);
		end
	end

	// Header checks.
	assign ver_bad = hdr_q.version != fmpf_pkg::IPV4_VERSION;
	assign need    = {1'b0, hdr_q.header_words, 2'b00} + fmpf_pkg::PORT_BYTES;
	assign trunc   = 16'(need) > hdr_q.first_len;

	always_comb begin
		header_res = '0;
		if (ver_bad) begin
			header_res.outcome = fmpf_pkg::OUTCOME_NOT_IPV4;
		end else if (trunc) begin
			header_res.outcome = fmpf_pkg::OUTCOME_TRUNCATED;
		end else begin
			header_res.outcome = fmpf_pkg::OUTCOME_NO_MATCH;
		end
	end

	// Ports count only for TCP.
	assign sport_eff = (hdr_q.protocol == fmpf_pkg::TCP_PROTOCOL) ? hdr_q.src_port_field : '0;
	assign dport_eff = (hdr_q.protocol == fmpf_pkg::TCP_PROTOCOL) ? hdr_q.dst_port_field : '0;

	always_comb begin
		if (32'(ptr_q) < STORED) begin
			cur = table_q[ptr_q[IDX_W-1:0]];
		end else begin
			cur = '0;
		end
	end

	assign hit = ((cur.proto == '0) || (cur.proto == hdr_q.protocol)) &&
		((cur.src == '0) || (cur.src == hdr_q.src_addr)) &&
		((cur.dst == '0) || (cur.dst == hdr_q.dst_addr)) &&
		((cur.sport == '0) || (cur.sport == sport_eff)) &&
		((cur.dport == '0) || (cur.dport == dport_eff));

	always_comb begin
		scan_res = '0;
		if (hit) begin
			scan_res.deny        = cur.deny;
			scan_res.outcome     = fmpf_pkg::OUTCOME_MATCHED;
			scan_res.rule_number = 3'(ptr_q);
		end else begin
			scan_res.outcome = fmpf_pkg::OUTCOME_NO_MATCH;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				fmpf_pkg::RES_HEADER: res_q <= header_res;
				fmpf_pkg::RES_SCAN:   res_q <= scan_res;
				default:              res_q <= header_res;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign st.item_write = item.operation == fmpf_pkg::OP_WRITE;
	assign st.header_ok  = !ver_bad && !trunc;
	assign st.scan_empty = limit == '0;
	assign st.hit        = hit;
	assign st.last       = ptr_inc == limit;
	assign st.out_free   = !out_valid_q || result_ready;

endmodule

`default_nettype wire

@@ hdl/first_match_packet_filter.sv @@
// Top level of the first-match five-tuple packet filter.
//
//   Channel  | Signals                              | Direction | Content
//   ---------+--------------------------------------+-----------+--------------------------
//   item     | item_valid, item_ready, item         | in        | classify or rule write
//   result   | result_valid, result_ready, result   | out       | verdict per classify
//   config   | cfg_wr_en, cfg_wr_data               | in        | rule_count register
//
// A rule write request is accepted and written into the table at the same edge, and the
// block is ready again in the next cycle.
// A classify request passes the header check and then compares the rules, one rule per cycle
// through a single comparator, at most min(rule_count, RULE_SLOTS) of them, up to the first
// match; a header that is not IPv4 or is truncated, or an empty rule set, skips the scan.
// No new request is taken until the verdict is handed off to the output register.
// Reset clears the rule table to all-wildcard allow rules and rule_count to zero at once.
// A finished verdict waits in the output register; a stalled result holds the sequencer in
// its hand-off state only when a second verdict is ready before the first is taken.
`default_nettype none

module first_match_packet_filter #(
	parameter int RULE_SLOTS = fmpf_pkg::RULE_SLOTS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [fmpf_pkg::COUNT_W-1:0]  cfg_wr_data,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire fmpf_pkg::item_t               item,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output fmpf_pkg::result_t                  result
);

	// Commands from the sequencer and status back from the datapath.
	fmpf_pkg::ctrl_cmd_t    cmd;
	fmpf_pkg::ctrl_status_t st;

	// The sequencer walks each classify request through header check, scan and hand-off.
	fmpf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	// The datapath holds the rule table, the captured header and the verdict registers.
	fmpf_dpath #(
		.RULE_SLOTS (RULE_SLOTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item         (item),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result),
		.cmd          (cmd),
		.st           (st)
	);

`ifndef NO_ASSERTIONS
	// A classify request keeps the block busy in the following cycle.
	a_classify_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && (item.operation == fmpf_pkg::OP_CLASSIFY))
		|=> !item_ready)
		else $error("ready right after a classify request");

	// The scan never steps past a matching rule.
	a_no_step_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_ptr |-> !st.hit)
		else $error("scan stepped past a matching rule");

	// A result appears only after the sequencer loads the output register.
	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.out_load))
		else $error("result shown without a load");

	// Table writes happen only on an accepted request.
	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.table_wr |-> (item_valid && item_ready))
		else $error("rule table written without an accepted request");
`endif

endmodule

`default_nettype wire

@@ dv/fmpf_verdict_checker.sv @@
// Checker that predicts filter verdicts from observed requests and compares them with results.
`default_nettype none

module fmpf_verdict_checker
	import fmpf_pkg::*;
#(
	parameter int RULE_SLOTS = RULE_SLOTS_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [COUNT_W-1:0] cfg_wr_data,
	input  wire logic               item_valid,
	input  wire logic               item_ready,
	input  wire item_t              item,
	input  wire logic               result_valid,
	input  wire logic               result_ready,
	input  wire result_t            result,
	output int                      mismatch_count,
	output int                      outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	rule_t              rule_table [RULE_SLOTS];
	logic [COUNT_W-1:0] active_rules;
	result_t            pending_verdicts [$];

	initial mismatch_count = 0;
	initial outstanding = 0;

	// A rule field of zero matches anything.
	function automatic bit field_hits(logic [31:0] rule_val, logic [31:0] pkt_val);
		return (rule_val == 32'd0) || (rule_val == pkt_val);
	endfunction

	function automatic result_t predict_verdict(item_t pkt);
		result_t     verdict;
		int unsigned needed;
		int          scan_len;
		logic [15:0] sport;
		logic [15:0] dport;
		rule_t       r;
		verdict.deny        = 1'b0;
		verdict.outcome     = OUTCOME_NO_MATCH;
		verdict.rule_number = 3'd0;
		if (pkt.version != IPV4_VERSION) begin
			verdict.outcome = OUTCOME_NOT_IPV4;
			return verdict;
		end
		needed = int'(pkt.header_words) * 4 + int'(PORT_BYTES);
		if (needed > int'(pkt.first_len)) begin
			verdict.outcome = OUTCOME_TRUNCATED;
			return verdict;
		end
		sport = (pkt.protocol == TCP_PROTOCOL) ? pkt.src_port_field : 16'd0;
		dport = (pkt.protocol == TCP_PROTOCOL) ? pkt.dst_port_field : 16'd0;
		scan_len = (int'(active_rules) > RULE_SLOTS) ? RULE_SLOTS : int'(active_rules);
		for (int i = 0; i < scan_len; i++) begin
			r = rule_table[i];
			if (field_hits(32'(r.proto), 32'(pkt.protocol)) &&
			    field_hits(r.src, pkt.src_addr) &&
			    field_hits(r.dst, pkt.dst_addr) &&
			    field_hits(32'(r.sport), 32'(sport)) &&
			    field_hits(32'(r.dport), 32'(dport))) begin
				verdict.deny        = r.deny;
				verdict.outcome     = OUTCOME_MATCHED;
				verdict.rule_number = 3'(i);
				return verdict;
			end
		end
		return verdict;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < RULE_SLOTS; i++) begin
				rule_table[i] = '0;
			end
			active_rules = '0;
			pending_verdicts.delete();
			outstanding = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t: verdict mismatch: expected none, got deny=%0b outcome=%0d rule=%0d",
					         $time, result.deny, result.outcome, result.rule_number);
					mismatch_count++;
				end else begin
					want = pending_verdicts.pop_front();
					if (result.deny !== want.deny || result.outcome !== want.outcome ||
					    result.rule_number !== want.rule_number) begin
						$display("%0t: verdict mismatch: expected deny=%0b outcome=%0d rule=%0d, got deny=%0b outcome=%0d rule=%0d",
						         $time, want.deny, want.outcome, want.rule_number,
						         result.deny, result.outcome, result.rule_number);
						mismatch_count++;
					end
				end
			end
			if (cfg_wr_en) begin
				active_rules = cfg_wr_data;
			end
			if (item_valid && item_ready) begin
				if (item.operation == OP_WRITE) begin
					if (int'(item.rule_index) < RULE_SLOTS) begin
						rule_table[item.rule_index] = '{proto: item.protocol,
						                                src: item.src_addr,
						                                dst: item.dst_addr,
						                                sport: item.src_port_field,
						                                dport: item.dst_port_field,
						                                deny: item.deny_flag};
					end
				end else begin
					pending_verdicts.push_back(predict_verdict(item));
				end
			end
			outstanding = pending_verdicts.size();
		end
	end

endmodule

`default_nettype wire

@@ dv/first_match_packet_filter_test.sv @@
// Testbench top for the first-match packet filter: stimulus, reset, timeout and verdict.
`default_nettype none

module first_match_packet_filter_test;

	import fmpf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles to let pass after the last verdict, covering a scan over the full table.
	localparam int SETTLE_CYCLES = 24;
	// Length of the deliberate result back-pressure stretch.
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 50;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_wr_en    = 1'b0;
	logic [COUNT_W-1:0] cfg_wr_data  = '0;
	logic               item_valid   = 1'b0;
	item_t              item         = '0;
	logic               result_ready = 1'b0;
	logic               item_ready;
	logic               result_valid;
	result_t            result;

	int mismatch_count;
	int outstanding;
	int burst_left = 0;

	// Set by the stimulus when the receiver should stop taking results for a long stretch.
	bit long_stall_request = 1'b0;

	logic [31:0] addr_pool [4];
	logic [15:0] port_pool [4];

	always begin
		#2;
		clk = 1'b1;
		#2;
		clk = 1'b0;
	end

	first_match_packet_filter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	fmpf_verdict_checker verdict_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.item           (item),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result         (result),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// The run is short; this bound is many times the slowest legal run and only trips on a hang.
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Builds a rule write request. The fields that a write ignores get random values so that
	// the block is shown to really ignore them.
	function automatic item_t rule_request(logic [2:0] idx, logic [7:0] proto, logic [31:0] src,
	                                       logic [31:0] dst, logic [15:0] sport,
	                                       logic [15:0] dport, logic deny);
		item_t r;
		r.operation      = OP_WRITE;
		r.rule_index     = idx;
		r.version        = 4'($urandom);
		r.header_words   = 4'($urandom);
		r.first_len      = 16'($urandom);
		r.protocol       = proto;
		r.src_addr       = src;
		r.dst_addr       = dst;
		r.src_port_field = sport;
		r.dst_port_field = dport;
		r.deny_flag      = deny;
		return r;
	endfunction

	// Builds a classify request; the index and action fields are don't-care here and are
	// randomized for the same reason.
	function automatic item_t packet_request(logic [3:0] ver, logic [3:0] hdr_words,
	                                         logic [15:0] len, logic [7:0] proto,
	                                         logic [31:0] src, logic [31:0] dst,
	                                         logic [15:0] sport, logic [15:0] dport);
		item_t r;
		r.operation      = OP_CLASSIFY;
		r.rule_index     = 3'($urandom);
		r.version        = ver;
		r.header_words   = hdr_words;
		r.first_len      = len;
		r.protocol       = proto;
		r.src_addr       = src;
		r.dst_addr       = dst;
		r.src_port_field = sport;
		r.dst_port_field = dport;
		r.deny_flag      = 1'($urandom);
		return r;
	endfunction

	// Packet fields mostly come from a small pool so that they hit the rules in the table.
	function automatic logic [31:0] pick_addr();
		return ($urandom_range(0, 4) != 0) ? addr_pool[$urandom_range(0, 3)] : $urandom;
	endfunction

	function automatic logic [15:0] pick_port();
		return ($urandom_range(0, 4) != 0) ? port_pool[$urandom_range(0, 3)] : 16'($urandom);
	endfunction

	function automatic logic [7:0] pick_proto();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			return TCP_PROTOCOL;
		end else if (sel < 8) begin
			return 8'd17;
		end
		return 8'($urandom);
	endfunction

	// Random request: mostly rule writes with pool content and well-formed IPv4 headers long
	// enough to reach the rule scan; the rest is noise with random fields and an often short length.
	function automatic item_t random_request();
		logic [3:0]  hdr_words;
		int unsigned need;
		int          kind;
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			return rule_request(3'($urandom),
			                    ($urandom_range(0, 1) != 0) ? 8'd0 : pick_proto(),
			                    ($urandom_range(0, 1) != 0) ? 32'd0 : pick_addr(),
			                    ($urandom_range(0, 1) != 0) ? 32'd0 : pick_addr(),
			                    ($urandom_range(0, 2) != 0) ? 16'd0 : pick_port(),
			                    ($urandom_range(0, 2) != 0) ? 16'd0 : pick_port(),
			                    1'($urandom));
		end else if (kind < 30) begin
			return rule_request(3'($urandom), 8'($urandom), $urandom, $urandom,
			                    16'($urandom), 16'($urandom), 1'($urandom));
		end else if (kind < 88) begin
			hdr_words = 4'($urandom_range(5, 15));
			need = int'(hdr_words) * 4 + 4;
			return packet_request(IPV4_VERSION, hdr_words,
			                      16'($urandom_range(need, need + 1500)),
			                      pick_proto(), pick_addr(), pick_addr(),
			                      pick_port(), pick_port());
		end
		return packet_request(4'($urandom), 4'($urandom),
		                      ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 70))
		                                                  : 16'($urandom),
		                      8'($urandom), $urandom, $urandom,
		                      16'($urandom), 16'($urandom));
	endfunction

	// Presents one request and holds it, unchanged, until the block takes it.
	task automatic send_request(item_t r);
		item       <= r;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	// Sends a request as part of a burst; when the burst runs out, the sender goes quiet for
	// a random gap and then starts a new burst of random length.
	task automatic offer(item_t r);
		send_request(r);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	// Waits until every verdict has come back, then lets a scan's worth of cycles pass so
	// that a trailing rule write has surely settled as well.
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the rule_count register. Only called while the block is idle.
	task automatic set_rule_count(int unsigned count);
		cfg_wr_data <= COUNT_W'(count);
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// The receiver alternates between always ready, random ready, short stalls and a
	// toggling pattern. On request it refuses results for a long stretch, so that the
	// verdict register and the sequencer fill up and the block stops taking requests.
	initial begin
		int chunk;
		int mode;
		@(posedge clk iff arst_n);
		forever begin
			if (long_stall_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_stall_request = 1'b0;
			end
			mode  = $urandom_range(0, 3);
			chunk = $urandom_range(1, 30);
			for (int i = 0; i < chunk; i++) begin
				case (mode)
					0: begin
						result_ready <= 1'b1;
					end
					1: begin
						result_ready <= 1'($urandom);
					end
					2: begin
						result_ready <= (i >= 8);
					end
					default: begin
						result_ready <= i[0];
					end
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		int unsigned counts [PHASES];
		for (int i = 0; i < 4; i++) begin
			addr_pool[i] = $urandom;
			port_pool[i] = 16'($urandom);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no rules in use: headers that are not IPv4, truncated headers one byte short of the
		// length limit, and well-formed headers right at the limit that fall through to the default.
		offer(packet_request(4'd3, 4'd5, 16'd100, TCP_PROTOCOL, 32'h0A000001, 32'h0A000002,
		                     16'd1234, 16'd80));
		offer(packet_request(4'd0, 4'd0, 16'd0, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0));
		offer(packet_request(4'd15, 4'd15, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
		                     16'hFFFF, 16'hFFFF));
		offer(packet_request(IPV4_VERSION, 4'd15, 16'd63, TCP_PROTOCOL, 32'd1, 32'd2,
		                     16'd3, 16'd4));
		offer(packet_request(IPV4_VERSION, 4'd0, 16'd3, TCP_PROTOCOL, 32'd1, 32'd2,
		                     16'd3, 16'd4));
		offer(packet_request(IPV4_VERSION, 4'd15, 16'd64, TCP_PROTOCOL, 32'd1, 32'd2,
		                     16'd3, 16'd4));
		offer(packet_request(IPV4_VERSION, 4'd0, 16'd4, 8'd17, 32'd1, 32'd2, 16'd3, 16'd4));

		// Load a few rules; entries four to six keep their reset value, an all-wildcard allow.
		offer(rule_request(3'd0, TCP_PROTOCOL, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80,
		                   1'b1));
		offer(rule_request(3'd1, 8'd17, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1));
		offer(rule_request(3'd2, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		offer(rule_request(3'd3, 8'd0, 32'd0, 32'd0, 16'd22, 16'd0, 1'b1));
		offer(rule_request(3'd7, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1));
		drain();
		set_rule_count(RULE_SLOTS_DEFAULT);

		// An exact hit on the first rule, a near miss that lands on a wildcard entry, a UDP
		// match, ports cleared for a protocol other than TCP, and a port-only rule.
		offer(packet_request(IPV4_VERSION, 4'd5, 16'd24, TCP_PROTOCOL, 32'h0A000001,
		                     32'h0A000002, 16'd1234, 16'd80));
		offer(packet_request(IPV4_VERSION, 4'd5, 16'd1500, TCP_PROTOCOL, 32'h0A000001,
		                     32'h0A000002, 16'd1234, 16'd81));
		offer(packet_request(IPV4_VERSION, 4'd5, 16'd1500, 8'd17, 32'h0A000001,
		                     32'h0A000002, 16'd53, 16'd53));
		offer(packet_request(IPV4_VERSION, 4'd5, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
		                     16'hFFFF, 16'hFFFF));
		offer(packet_request(IPV4_VERSION, 4'd6, 16'd100, TCP_PROTOCOL, 32'h12345678,
		                     32'h9ABCDEF0, 16'd22, 16'd4000));
		drain();

		// A count above the table size is clamped to the table size.
		set_rule_count(COUNT_MAX);
		offer(packet_request(IPV4_VERSION, 4'd5, 16'd200, TCP_PROTOCOL, 32'h01020304,
		                     32'h05060708, 16'd22, 16'd443));
		drain();

		// With only the first rule active, UDP traffic falls through to the default.
		set_rule_count(1);
		offer(packet_request(IPV4_VERSION, 4'd5, 16'd200, 8'd17, 32'h0A000001, 32'h0A000002,
		                     16'd1234, 16'd80));
		offer(packet_request(IPV4_VERSION, 4'd5, 16'd200, TCP_PROTOCOL, 32'h0A000001,
		                     32'h0A000002, 16'd1234, 16'd80));

		// Random phases, each with its own rule count, the extremes among them.
		counts = '{0, 8, 15, 1, 4, 8, 7, 15};
		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_rule_count((p >= 4) ? $urandom_range(0, COUNT_MAX) : counts[p]);
			if (p == 1) begin
				long_stall_request = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				offer(random_request());
			end
		end
		drain();
		set_rule_count(counts[PHASES - 1]);

		if (mismatch_count == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
hdl/fmpf_pkg.sv
hdl/fmpf_ctrl.sv
hdl/fmpf_dpath.sv
hdl/first_match_packet_filter.sv
dv/fmpf_verdict_checker.sv
dv/first_match_packet_filter_test.sv
